// File: rtl/core/rmf_pkg.sv
`timescale 1ns / 1ps

package rmf_pkg;

  localparam int MAX_HALF    = 15;
  localparam int SAMPLE_BITS = 16;
  localparam int DEPTH       = 2 * MAX_HALF + 1;
  // counts up to DEPTH, ages and ranks up to DEPTH-1
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int AGE_W       = $clog2(DEPTH);
  localparam int HALF_W      = 4;

  localparam logic [HALF_W-1:0] WIN_HALF_RST = HALF_W'(12);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // value circulating along the chain during ranking
  typedef struct packed {
    sample_t            val;
    logic [AGE_W-1:0]   age;
    logic               act;
  } tok_t;

  typedef struct packed {
    logic               shift;
    logic               rank;
    logic [CNT_W-1:0]   span;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RANK,
    ST_PICK,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/core/rmf_if.sv
`timescale 1ns / 1ps

interface rmf_in_if;
  logic               valid;
  logic               ready;
  rmf_pkg::sample_t   sample;
  logic               is_last;

  modport source(output valid, sample, is_last, input ready);
  modport sink(input valid, sample, is_last, output ready);
endinterface

interface rmf_out_if;
  logic               valid;
  logic               ready;
  rmf_pkg::sample_t   median_value;
  logic               end_of_run;
  logic               short_stream;

  modport source(output valid, median_value, end_of_run, short_stream, input ready);
  modport sink(input valid, median_value, end_of_run, short_stream, output ready);
endinterface

interface rmf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rmf_pkg::HALF_W-1:0]      window_half;

  modport source(output valid, window_half, input ready);
  modport sink(input valid, window_half, output ready);
endinterface

// File: rtl/core/rmf_cell.sv
`timescale 1ns / 1ps

module rmf_cell (
  input  logic                        clk,
  input  rmf_pkg::cell_ctl_t          ctl,
  input  logic [rmf_pkg::AGE_W-1:0]   age,
  input  rmf_pkg::sample_t            val_in,
  input  rmf_pkg::tok_t               tok_in,
  output rmf_pkg::sample_t            val,
  output rmf_pkg::tok_t               tok,
  output logic [rmf_pkg::AGE_W-1:0]   rank,
  output logic                        act
);

  logic in_window;
  logic tok_below;

  assign in_window = rmf_pkg::CNT_W'(age) < ctl.span;

  // ties broken by age so that ranks inside the window are all distinct
  assign tok_below = tok.act &&
                     ((tok.val < val) || ((tok.val == val) && (tok.age < age)));

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      val      <= val_in;
      act      <= in_window;
      tok.val  <= val_in;
      tok.age  <= age;
      tok.act  <= in_window;
      rank     <= '0;
    end else if (ctl.rank) begin
      tok <= tok_in;
      if (tok_below) begin
        rank <= rank + 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/rmf_ctrl.sv
`timescale 1ns / 1ps

module rmf_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  rmf_in_if.sink                      samples,
  rmf_out_if.source                   results,
  rmf_cfg_if.sink                     cfg,
  input  rmf_pkg::sample_t            pick,
  output rmf_pkg::cell_ctl_t          ctl,
  output logic [rmf_pkg::AGE_W-1:0]   mid
);

  localparam int CW = rmf_pkg::CNT_W;

  rmf_pkg::state_t                 state;
  rmf_pkg::state_t                 state_next;
  logic [CW-1:0]                   seen;
  logic [rmf_pkg::HALF_W-1:0]      win_half;
  logic [CW-1:0]                   span;
  logic [CW-1:0]                   remain;
  logic [rmf_pkg::AGE_W-1:0]       step;
  logic                            short_flag;
  rmf_pkg::sample_t                med;

  logic                            accept;
  logic [CW-1:0]                   h_eff;
  logic [CW-1:0]                   wlen;
  logic [CW:0]                     seen_p1;
  logic [CW-1:0]                   seen_inc;
  logic                            full;
  logic                            first;
  logic                            emit_any;
  logic [CW-1:0]                   span_next;
  logic [CW-1:0]                   count_next;
  logic                            short_next;
  logic                            rank_done;

  assign accept    = samples.valid && samples.ready;
  assign rank_done = (step == rmf_pkg::AGE_W'(rmf_pkg::DEPTH - 1));
  assign mid       = rmf_pkg::AGE_W'(span >> 1);

  always_comb begin
    h_eff = (CW'(win_half) > CW'(rmf_pkg::MAX_HALF)) ? CW'(rmf_pkg::MAX_HALF)
                                                     : CW'(win_half);
    wlen     = CW'({h_eff, 1'b1});
    seen_p1  = {1'b0, seen} + 1'b1;
    seen_inc = (seen < CW'(rmf_pkg::DEPTH)) ? seen_p1[CW-1:0] : seen;
    full     = seen_p1 >= {1'b0, wlen};
    first    = seen_p1 == {1'b0, wlen};
    if (full) begin
      emit_any   = 1'b1;
      span_next  = wlen;
      count_next = (first ? h_eff + 1'b1 : CW'(1)) + (samples.is_last ? h_eff : '0);
      short_next = 1'b0;
    end else begin
      emit_any   = samples.is_last;
      span_next  = seen_inc;
      count_next = seen_inc;
      short_next = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rmf_pkg::ST_IDLE: begin
        if (accept && emit_any) begin
          state_next = rmf_pkg::ST_RANK;
        end
      end
      rmf_pkg::ST_RANK: begin
        if (rank_done) begin
          state_next = rmf_pkg::ST_PICK;
        end
      end
      rmf_pkg::ST_PICK: begin
        state_next = rmf_pkg::ST_EMIT;
      end
      rmf_pkg::ST_EMIT: begin
        if (results.ready && remain == CW'(1)) begin
          state_next = rmf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rmf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    samples.ready        = (state == rmf_pkg::ST_IDLE);
    results.valid        = (state == rmf_pkg::ST_EMIT);
    results.median_value = med;
    results.end_of_run   = (remain == CW'(1));
    results.short_stream = short_flag;
    cfg.ready            = 1'b1;
    ctl.shift            = accept;
    ctl.rank             = (state == rmf_pkg::ST_RANK);
    ctl.span             = span_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rmf_pkg::ST_IDLE;
      seen     <= '0;
      win_half <= rmf_pkg::WIN_HALF_RST;
      remain   <= '0;
      step     <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        win_half <= cfg.window_half;
      end
      if (accept) begin
        // a marked last word closes the series
        seen   <= samples.is_last ? '0 : seen_inc;
        remain <= count_next;
        step   <= '0;
      end
      if (state == rmf_pkg::ST_RANK) begin
        step <= step + 1'b1;
      end
      if (results.valid && results.ready) begin
        remain <= remain - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      span       <= span_next;
      short_flag <= short_next;
    end
    if (state == rmf_pkg::ST_PICK) begin
      med <= pick;
    end
  end

  a_emit_has_words: assert property (@(posedge clk) disable iff (rst)
    (state == rmf_pkg::ST_EMIT) |-> (remain != '0))
    else $error("emit state with no words left");

  a_accept_starts_rank: assert property (@(posedge clk) disable iff (rst)
    (accept && emit_any) |=> (state == rmf_pkg::ST_RANK && step == '0))
    else $error("accepted word with results did not start ranking");

  a_last_word_idles: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.ready && remain == CW'(1)) |=> (state == rmf_pkg::ST_IDLE))
    else $error("did not return to idle after final result");

  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    seen <= CW'(rmf_pkg::DEPTH))
    else $error("sample count beyond window depth");

  a_span_bound: assert property (@(posedge clk) disable iff (rst)
    (state == rmf_pkg::ST_PICK) |-> (span != '0 && span <= CW'(rmf_pkg::DEPTH)))
    else $error("median span out of range");

endmodule

// File: rtl/core/running_median_filter.sv
`timescale 1ns / 1ps

// channel   dir  payload                                     word moves when
// samples   in   sample[15:0] signed, is_last                valid && ready
// results   out  median_value[15:0] signed, end_of_run,      valid && ready
//                short_stream
// cfg       in   window_half[3:0]                            valid && ready
//
// A word that yields no result leaves the block idle. A word that yields
// results is ranked, picked and emitted: ranking rotates every cell's
// value once around the chain of 31 cells, each cell counting smaller values.
// samples.ready is high only when idle; a stalled result holds its word.
// rst is synchronous: series count and state clear, window_half returns to 12.

module running_median_filter (
  input  logic        clk,
  input  logic        rst,
  rmf_in_if.sink      samples,
  rmf_out_if.source   results,
  rmf_cfg_if.sink     cfg
);

  localparam int D = rmf_pkg::DEPTH;

  rmf_pkg::cell_ctl_t               ctl;
  logic [rmf_pkg::AGE_W-1:0]        mid;
  rmf_pkg::sample_t                 pick;
  rmf_pkg::sample_t                 val  [D];
  rmf_pkg::tok_t                    tok  [D];
  logic [rmf_pkg::AGE_W-1:0]        rank [D];
  logic [D-1:0]                     act;

  rmf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results),
    .cfg     (cfg),
    .pick    (pick),
    .ctl     (ctl),
    .mid     (mid)
  );

  // cell 0 holds the newest sample; tokens wrap from the far end back to cell 0
  for (genvar i = 0; i < D; i++) begin : g_cell
    rmf_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .age    (rmf_pkg::AGE_W'(i)),
      .val_in ((i == 0) ? samples.sample : val[(i + D - 1) % D]),
      .tok_in (tok[(i + D - 1) % D]),
      .val    (val[i]),
      .tok    (tok[i]),
      .rank   (rank[i]),
      .act    (act[i])
    );
  end

  // exactly one active cell carries the middle rank
  always_comb begin
    pick = '0;
    for (int i = 0; i < D; i++) begin
      if (act[i] && rank[i] == mid) begin
        pick = pick | val[i];
      end
    end
  end

endmodule
